>>> rtl/itiu_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths, codes and helpers for the inverse table interpolator.
// No dependencies; used by the interpolator top level and the checker.
package itiu_pkg;

  // Field widths fixed by the item format
  localparam int OP_W       = 1;
  localparam int REACH_W    = 2;
  localparam int INDEX_W    = 10;
  localparam int DATA_W     = 32;
  localparam int STEP_W     = 20;
  localparam int LEN_W      = 11;
  localparam int HEIGHT_W   = 30;
  localparam int STATUS_W   = 2;
  localparam int PROD_W     = DATA_W + STEP_W;

  // Stream and APB widths
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 32;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;

  // Field offsets in in_tdata
  localparam int IN_REACH_LSB = 0;
  localparam int IN_INDEX_LSB = IN_REACH_LSB + REACH_W;
  localparam int IN_VALUE_LSB = IN_INDEX_LSB + INDEX_W;
  localparam int IN_DISCH_LSB = IN_VALUE_LSB + DATA_W;

  // Parameter defaults
  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int REACHES_DEF     = 4;

  // Register reset values
  localparam logic [STEP_W-1:0] CALIB_STEP_RST   = STEP_W'(655);
  localparam logic [LEN_W-1:0]  TABLE_LENGTH_RST = LEN_W'(1024);

  // Register indexes (paddr[2])
  localparam logic REG_CALIB_STEP   = 1'b0;
  localparam logic REG_TABLE_LENGTH = 1'b1;

  // Item kinds
  localparam logic [OP_W-1:0] OP_WRITE = 1'b0;
  localparam logic [OP_W-1:0] OP_QUERY = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NEG   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ABOVE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FLAT  = 2'd3;

  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = {HEIGHT_W{1'b1}};

  // Clamp a wide height to the output range
  function automatic logic [HEIGHT_W-1:0] sat_height(input logic [PROD_W:0] h);
    logic [PROD_W:0] lim;
    lim = (PROD_W + 1)'(HEIGHT_MAX);
    sat_height = (h > lim) ? HEIGHT_MAX : h[HEIGHT_W-1:0];
  endfunction

endpackage

>>> rtl/inverse_table_interpolator_unit.sv
`timescale 1ns / 1ps
// Inverse table interpolator: height from discharge over per-reach tables.
// Depends on itiu_pkg, itiu_ram and itiu_div.
//
//  channel | dir | signals                                  | transfer when
//  --------+-----+------------------------------------------+---------------------------
//  in_     | in  | in_tvalid/in_tready, in_tdata, in_tuser  | in_tvalid & in_tready
//  out_    | out | out_tvalid/out_tready, out_tdata, out_tuser | out_tvalid & out_tready
//  cfg_    | in  | APB: psel, penable, pwrite, paddr, pwdata | psel&penable&pwrite&pready
//
// A table write gives no result. A query with a negative or zero discharge is
// answered the cycle after its transfer. Other queries run a linear search that
// reads up to n samples (n the clamped table length), one a cycle, from the
// single RAM read port; one shared multiplier and a serial divider then finish
// the interpolation, the divider skipped on a flat segment or above the table.
// in_tready is low from a query transfer until its result has been taken.
// Reset (rst_n, synchronous) clears control and restores the registers; the
// table is not cleared and must be written before it is queried.
module inverse_table_interpolator_unit #(
  parameter int TABLE_DEPTH = itiu_pkg::TABLE_DEPTH_DEF,
  parameter int REACHES     = itiu_pkg::REACHES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: reach[1:0], entry_index[11:2], entry_value[43:12],
  //           discharge[75:44], zero fill[79:76]
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [itiu_pkg::IN_TDATA_W-1:0]   in_tdata,
  // in_tuser: op[0]
  input  logic [itiu_pkg::OP_W-1:0]         in_tuser,
  // out_tdata: height[29:0], zero fill[31:30]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [itiu_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // out_tuser: status[1:0]
  output logic [itiu_pkg::STATUS_W-1:0]     out_tuser,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [itiu_pkg::CFG_AW-1:0]       cfg_paddr,
  input  logic [itiu_pkg::CFG_DW-1:0]       cfg_pwdata,
  output logic [itiu_pkg::CFG_DW-1:0]       cfg_prdata,
  output logic                              cfg_pready
);

  localparam int DEPTH  = REACHES * TABLE_DEPTH;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int RCH_W  = (REACHES > 1) ? $clog2(REACHES) : 1;
  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] N_MAX = CNT_W'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_MUL_H,
    S_H_CHK,
    S_MUL_D,
    S_DIV_GO,
    S_DIV_WAIT,
    S_OUT
  } state_t;

  // Reach number folded into the configured count of reaches
  function automatic logic [RCH_W-1:0] wrap_reach(input logic [itiu_pkg::REACH_W-1:0] r);
    int v;
    v = int'(r);
    for (int k = 0; k < 4; k++) begin
      if (v >= REACHES) begin
        v = v - REACHES;
      end
    end
    wrap_reach = RCH_W'(v);
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [itiu_pkg::STEP_W-1:0] calib_step_r;
  logic [itiu_pkg::LEN_W-1:0]  table_length_r;
  logic                        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calib_step_r   <= itiu_pkg::CALIB_STEP_RST;
      table_length_r <= itiu_pkg::TABLE_LENGTH_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        itiu_pkg::REG_CALIB_STEP:   calib_step_r   <= cfg_pwdata[itiu_pkg::STEP_W-1:0];
        itiu_pkg::REG_TABLE_LENGTH: table_length_r <= cfg_pwdata[itiu_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      itiu_pkg::REG_CALIB_STEP:
        cfg_prdata = itiu_pkg::CFG_DW'(calib_step_r);
      itiu_pkg::REG_TABLE_LENGTH:
        cfg_prdata = itiu_pkg::CFG_DW'(table_length_r);
      default:
        cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input field decode
  // ---------------------------------------------------------------------------
  logic [itiu_pkg::REACH_W-1:0] in_reach;
  logic [itiu_pkg::INDEX_W-1:0] in_index;
  logic [itiu_pkg::DATA_W-1:0]  in_value;
  logic [itiu_pkg::DATA_W-1:0]  in_disch;
  logic [ADDR_W-1:0]            in_base;
  logic                         in_xfer;
  logic                         idx_ok;
  logic [ADDR_W-1:0]            wr_addr;
  logic                         wr_en;
  logic [CNT_W-1:0]             n_clamp;

  assign in_reach = in_tdata[itiu_pkg::IN_REACH_LSB +: itiu_pkg::REACH_W];
  assign in_index = in_tdata[itiu_pkg::IN_INDEX_LSB +: itiu_pkg::INDEX_W];
  assign in_value = in_tdata[itiu_pkg::IN_VALUE_LSB +: itiu_pkg::DATA_W];
  assign in_disch = in_tdata[itiu_pkg::IN_DISCH_LSB +: itiu_pkg::DATA_W];

  assign in_xfer = in_tvalid && in_tready;
  assign in_base = ADDR_W'(int'(wrap_reach(in_reach)) * TABLE_DEPTH);
  assign idx_ok  = (int'(in_index) < TABLE_DEPTH);
  assign wr_addr = ADDR_W'(int'(in_base) + int'(in_index));
  assign wr_en   = in_xfer && (in_tuser == itiu_pkg::OP_WRITE) && idx_ok;

  // Samples in use: zero counts as one, anything above the depth saturates
  always_comb begin
    if (table_length_r == '0) begin
      n_clamp = CNT_W'(1);
    end else if (int'(table_length_r) > TABLE_DEPTH) begin
      n_clamp = N_MAX;
    end else begin
      n_clamp = CNT_W'(table_length_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------------
  state_t                        state_r;
  logic [itiu_pkg::DATA_W-2:0]   d_r;       // positive discharge
  logic [CNT_W-1:0]              n_r;
  logic [ADDR_W-1:0]             base_r;
  logic [CNT_W-1:0]              rd_i_r;    // next sample to read
  logic [CNT_W-1:0]              cmp_i_r;   // sample arriving from the RAM
  logic                          vld_r;
  logic [itiu_pkg::DATA_W-1:0]   q1_r;
  logic [itiu_pkg::DATA_W-1:0]   q2_r;
  logic [IDX_W-1:0]              hidx_r;
  logic                          above_r;
  logic [itiu_pkg::PROD_W-1:0]   prod_r;
  logic [itiu_pkg::PROD_W-1:0]   h1_r;
  logic [itiu_pkg::HEIGHT_W-1:0] height_r;
  logic [itiu_pkg::STATUS_W-1:0] status_r;

  // Sample RAM, all reaches back to back
  logic                          rd_en;
  logic [ADDR_W-1:0]             rd_addr;
  logic [itiu_pkg::DATA_W-1:0]   ram_q;

  assign rd_en   = (state_r == S_SEARCH) && (rd_i_r < n_r);
  assign rd_addr = ADDR_W'(base_r + ADDR_W'(rd_i_r));

  itiu_ram #(
    .WIDTH (itiu_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (in_value),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // Shared multiplier: step height first, then the interpolation numerator
  logic [itiu_pkg::DATA_W-1:0] mul_a;
  logic [itiu_pkg::PROD_W-1:0] mul_p;

  always_comb begin
    if (state_r == S_MUL_D) begin
      mul_a = {1'b0, d_r} - q1_r;
    end else begin
      mul_a = itiu_pkg::DATA_W'(hidx_r);
    end
    mul_p = itiu_pkg::PROD_W'(mul_a) * itiu_pkg::PROD_W'(calib_step_r);
  end

  // Serial divider for (d - q1) * step / (q2 - q1)
  logic                        div_start;
  logic                        div_done;
  logic [itiu_pkg::PROD_W-1:0] div_quot;
  logic [itiu_pkg::PROD_W:0]   sum_nxt;

  assign div_start = (state_r == S_DIV_GO);
  assign sum_nxt   = (itiu_pkg::PROD_W + 1)'(h1_r) + (itiu_pkg::PROD_W + 1)'(div_quot);

  itiu_div #(
    .NUM_W (itiu_pkg::PROD_W),
    .DEN_W (itiu_pkg::DATA_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (prod_r),
    .den   (q2_r - q1_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vld_r   <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_xfer && (in_tuser == itiu_pkg::OP_QUERY)) begin
            if (in_disch[itiu_pkg::DATA_W-1]) begin
              height_r <= '0;
              status_r <= itiu_pkg::ST_NEG;
              state_r  <= S_OUT;
            end else if (in_disch == '0) begin
              height_r <= '0;
              status_r <= itiu_pkg::ST_OK;
              state_r  <= S_OUT;
            end else begin
              d_r     <= in_disch[itiu_pkg::DATA_W-2:0];
              n_r     <= n_clamp;
              base_r  <= in_base;
              rd_i_r  <= '0;
              cmp_i_r <= '0;
              vld_r   <= 1'b0;
              state_r <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          vld_r <= rd_en;
          if (rd_en) begin
            rd_i_r <= rd_i_r + CNT_W'(1);
          end
          if (vld_r) begin
            if (ram_q < {1'b0, d_r}) begin
              q1_r <= ram_q;
              if (cmp_i_r == n_r - CNT_W'(1)) begin
                // discharge above every sample in use
                hidx_r  <= IDX_W'(n_r - CNT_W'(1));
                above_r <= 1'b1;
                vld_r   <= 1'b0;
                state_r <= S_MUL_H;
              end else begin
                cmp_i_r <= cmp_i_r + CNT_W'(1);
              end
            end else begin
              q2_r  <= ram_q;
              vld_r <= 1'b0;
              if (cmp_i_r == '0) begin
                // first sample already at or above the discharge
                height_r <= '0;
                status_r <= itiu_pkg::ST_OK;
                state_r  <= S_OUT;
              end else begin
                hidx_r  <= IDX_W'(cmp_i_r - CNT_W'(1));
                above_r <= 1'b0;
                state_r <= S_MUL_H;
              end
            end
          end
        end
        S_MUL_H: begin
          prod_r  <= mul_p;
          state_r <= S_H_CHK;
        end
        S_H_CHK: begin
          h1_r <= prod_r;
          if (above_r) begin
            height_r <= itiu_pkg::sat_height((itiu_pkg::PROD_W + 1)'(prod_r));
            status_r <= itiu_pkg::ST_ABOVE;
            state_r  <= S_OUT;
          end else if (q2_r <= q1_r) begin
            // flat segment: no division
            height_r <= itiu_pkg::sat_height((itiu_pkg::PROD_W + 1)'(prod_r));
            status_r <= itiu_pkg::ST_FLAT;
            state_r  <= S_OUT;
          end else begin
            state_r <= S_MUL_D;
          end
        end
        S_MUL_D: begin
          prod_r  <= mul_p;
          state_r <= S_DIV_GO;
        end
        S_DIV_GO: begin
          state_r <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            height_r <= itiu_pkg::sat_height(sum_nxt);
            status_r <= itiu_pkg::ST_OK;
            state_r  <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_tready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = itiu_pkg::OUT_TDATA_W'(height_r);
  assign out_tuser  = status_r;

endmodule

>>> rtl/itiu_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module itiu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

>>> rtl/itiu_div.sv
`timescale 1ns / 1ps
// Restoring serial divider, one quotient bit per cycle.
// No dependencies; used by the interpolator top level.
module itiu_div #(
  parameter int NUM_W = 52,
  parameter int DEN_W = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W:0]   rem_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] den_r;

  logic [DEN_W:0]   rem_sh;
  logic             ge;
  logic [DEN_W:0]   rem_nxt;

  always_comb begin
    rem_sh  = {rem_r[DEN_W-1:0], quo_r[NUM_W-1]};
    ge      = (rem_sh >= {1'b0, den_r});
    rem_nxt = ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
        rem_r  <= '0;
        quo_r  <= num;
        den_r  <= den;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[NUM_W-2:0], ge};
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

>>> rtl/itiu_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the inverse table interpolator, bound to the top level.
// Depends on itiu_pkg and inverse_table_interpolator_unit.
module itiu_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [itiu_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic [itiu_pkg::OP_W-1:0]        in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [itiu_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [itiu_pkg::STATUS_W-1:0]    out_tuser,
  input logic                             cfg_psel,
  input logic                             cfg_penable,
  input logic                             cfg_pwrite,
  input logic [itiu_pkg::CFG_AW-1:0]      cfg_paddr,
  input logic [itiu_pkg::CFG_DW-1:0]      cfg_pwdata,
  input logic [itiu_pkg::CFG_DW-1:0]      cfg_prdata,
  input logic                             cfg_pready
);

  // One item in flight: never taking input while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input taken while a result is pending");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // Negative discharge always reports zero height
  a_neg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == itiu_pkg::ST_NEG) |-> (out_tdata == '0))
    else $error("negative discharge with non-zero height");

  // A table write finishes at once and gives no result
  a_write_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == itiu_pkg::OP_WRITE) |=> in_tready && !out_tvalid)
    else $error("table write stalled the block or gave a result");

  // A query transfer lowers in_tready
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == itiu_pkg::OP_QUERY) |=> !in_tready)
    else $error("input taken while a query is in progress");

endmodule

bind inverse_table_interpolator_unit itiu_checker u_itiu_checker (.*);
